// ===== hw/rtl/bsel_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsel_pkg - shared types and constants of the backend selector
// Field widths, request, mode and status codes, register indexes, the
// command word between the front and back parts, and the result word.
// ----------------------------------------------------------------------------
package bsel_pkg;

  // Default sizes of the per-backend storage
  localparam int MAX_BACKENDS_DEF = 8;
  localparam int CONN_BITS_DEF    = 16;
  localparam int WEIGHT_BITS_DEF  = 8;

  // Fixed field widths
  localparam int REQ_TYPE_W = 2;
  localparam int BYTE_W     = 8;
  localparam int TARGET_W   = 3;
  localparam int CHOSEN_W   = 3;
  localparam int TOTAL_W    = 32;
  localparam int OPEN_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int HASH_W     = 32;
  localparam int HASH_SHIFT = 5;
  localparam int MODE_W     = 2;
  localparam int COUNT_W    = 4;
  localparam int WEIGHTS_W  = 64;
  localparam int CFG_ADDR_W = 2;
  localparam int CMDQ_DEPTH = 2;

  // Stream widths, padded to whole bytes
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 56;

  localparam logic [WEIGHTS_W-1:0] WEIGHTS_RESET = 64'h0101_0101_0101_0101;

  // Request kinds
  localparam logic [REQ_TYPE_W-1:0] REQ_SELECT = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_KEY    = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_OPEN   = 2'd2;
  localparam logic [REQ_TYPE_W-1:0] REQ_CLOSE  = 2'd3;

  // Selection modes
  localparam logic [MODE_W-1:0] MODE_RR       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEAST    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WEIGHTED = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HASH     = 2'd3;

  // Result status
  localparam logic [STATUS_W-1:0] STAT_SELECTED  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_UPDATED   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_BACKEND = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_OUT_RANGE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WEIGHTS = 2'd2;

  // Command word from the front part to the back part
  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic [HASH_W-1:0]     hash;
    logic [TARGET_W-1:0]   target;
  } cmd_t;

  // Live configuration seen by the back part
  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [COUNT_W-1:0]   count;
    logic [WEIGHTS_W-1:0] weights;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OPEN_W-1:0]   open_conn;
    logic [TOTAL_W-1:0]  total;
    logic [CHOSEN_W-1:0] chosen;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bsel_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsel_front - input classifier
// Folds client key bytes into the running hash and forwards select and
// connection requests, with a hash snapshot, to the command queue.
// ----------------------------------------------------------------------------
module bsel_front import bsel_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire logic [REQ_TYPE_W-1:0] req_type_i,
  input  wire logic [BYTE_W-1:0]     key_byte_i,
  input  wire logic [TARGET_W-1:0]   target_i,
  input  wire logic                  full_i,
  output logic                       push_o,
  output cmd_t                       cmd_o
);

  logic [HASH_W-1:0] hash_q, hash_d;
  logic              accept;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign push_o  = accept && (req_type_i != REQ_KEY);

  assign cmd_o.req_type = req_type_i;
  assign cmd_o.hash     = hash_q;
  assign cmd_o.target   = target_i;

  always_comb begin
    hash_d = hash_q;
    if (accept) begin
      if (req_type_i == REQ_KEY) begin
        // hash * 33 + byte, wrapping
        hash_d = (hash_q << HASH_SHIFT) + hash_q + HASH_W'(key_byte_i);
      end else if (req_type_i == REQ_SELECT) begin
        hash_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bsel_cmd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsel_cmd_fifo - command queue between front and back
// Small flip-flop queue; lets the front keep accepting while the back works.
// ----------------------------------------------------------------------------
module bsel_cmd_fifo import bsel_pkg::*; #(
  parameter int DEPTH = CMDQ_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          wr_en, rd_en;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bsel_mod_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsel_mod_unit - iterative remainder of the key hash by the backend count
// Radix-4 restoring reduction, two dividend bits per cycle.
// ----------------------------------------------------------------------------
module bsel_mod_unit import bsel_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [HASH_W-1:0]  dividend_i,
  input  wire logic [COUNT_W-1:0] divisor_i,
  output logic                    done_o,
  output logic [COUNT_W-1:0]      rem_o
);

  localparam int STEPS = HASH_W / 2;
  localparam int SW    = $clog2(STEPS);
  localparam int VW    = COUNT_W + 2;

  logic              busy_q, done_q;
  logic [SW-1:0]     step_q;
  logic [HASH_W-1:0] dvd_q;
  logic [COUNT_W-1:0] rem_q, div_q;
  logic [VW-1:0]     val, c1, c2, c3, val_red;

  assign val = {rem_q, dvd_q[HASH_W-1 -: 2]};
  assign c1  = VW'(div_q);
  assign c2  = c1 << 1;
  assign c3  = c1 + c2;

  // Partial remainder stays below 4x divisor: one of three subtractions
  always_comb begin
    if (val >= c3) begin
      val_red = val - c3;
    end else if (val >= c2) begin
      val_red = val - c2;
    end else if (val >= c1) begin
      val_red = val - c1;
    end else begin
      val_red = val;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 2;
      rem_q <= COUNT_W'(val_red);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == SW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < div_q))
    else $error("remainder not reduced below divisor");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("remainder started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("remainder done while still busy");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/bsel_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsel_back - selection and connection bookkeeping
// Pops commands, picks a backend in the configured mode, keeps per-backend
// open and request counts, and holds the result in an output register.
// ----------------------------------------------------------------------------
module bsel_back import bsel_pkg::*; #(
  parameter int MAX_BACKENDS = MAX_BACKENDS_DEF,
  parameter int CONN_BITS    = CONN_BITS_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  wire logic cfg_clr_i,
  input  wire logic cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output res_t      res_o
);

  localparam int BW = $clog2(MAX_BACKENDS);
  localparam int CW = (BW > COUNT_W) ? BW : COUNT_W;
  localparam int P  = 1 << BW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]           state_q, state_d;
  cmd_t                 cmd_q;
  logic                 out_valid_q;
  res_t                 res_q, res_d;

  logic [CONN_BITS-1:0] conn_q [MAX_BACKENDS];
  logic [TOTAL_W-1:0]   req_q  [MAX_BACKENDS];
  logic [BW-1:0]        rr_q, wsel_q;
  logic [WEIGHT_BITS-1:0] wpos_q;

  logic                 div_start, div_done;
  logic [COUNT_W-1:0]   div_rem;

  logic [WEIGHT_BITS-1:0] w_arr [MAX_BACKENDS];
  logic [WEIGHT_BITS-1:0] w_cur;

  logic [CONN_BITS-1:0] tv   [1:2*P-1];
  logic [BW-1:0]        ti   [1:2*P-1];
  logic                 tvld [1:2*P-1];

  logic                 is_sel, no_be, oor, exec_fire, w_wrap;
  logic [BW-1:0]        rr_sel, rr_next, wsel_next, sel, idx;
  logic [WEIGHT_BITS-1:0] wpos_next;
  logic [CONN_BITS-1:0] conn_cur, conn_new;
  logic [TOTAL_W-1:0]   req_cur;

  // Per-backend weights: zero counts as one, beyond byte eight weight is one
  for (genvar g = 0; g < MAX_BACKENDS; g++) begin : g_weight
    if (g < 8) begin : g_cfg
      logic [WEIGHT_BITS-1:0] raw;
      assign raw      = cfg_i.weights[8*g +: WEIGHT_BITS];
      assign w_arr[g] = (raw == '0) ? WEIGHT_BITS'(1) : raw;
    end else begin : g_one
      assign w_arr[g] = WEIGHT_BITS'(1);
    end
  end

  assign w_cur = w_arr[wsel_q];

  // Least-connections search: min tree, left child wins ties (lower index)
  always_comb begin
    for (int i = 0; i < P; i++) begin
      if (i < MAX_BACKENDS) begin
        tv[P+i]   = conn_q[i];
        tvld[P+i] = (CW'(i) < CW'(cfg_i.count));
      end else begin
        tv[P+i]   = '0;
        tvld[P+i] = 1'b0;
      end
      ti[P+i] = BW'(i);
    end
    for (int n = P - 1; n >= 1; n--) begin
      if (tvld[2*n] && (!tvld[2*n+1] || tv[2*n] <= tv[2*n+1])) begin
        tv[n] = tv[2*n];
        ti[n] = ti[2*n];
      end else begin
        tv[n] = tv[2*n+1];
        ti[n] = ti[2*n+1];
      end
      tvld[n] = tvld[2*n] || tvld[2*n+1];
    end
  end

  // Round robin: stale pointer falls back to backend 0
  assign rr_sel  = (CW'(rr_q) < CW'(cfg_i.count)) ? rr_q : '0;
  assign rr_next = ((CW'(rr_sel) + CW'(1)) == CW'(cfg_i.count)) ? '0 : rr_sel + 1'b1;

  // Weighted: walk each backend for as many selects as its weight
  assign w_wrap    = (wpos_q == w_cur - 1'b1);
  assign wpos_next = w_wrap ? '0 : wpos_q + 1'b1;
  assign wsel_next = !w_wrap ? wsel_q :
                     (((CW'(wsel_q) + CW'(1)) == CW'(cfg_i.count)) ? '0 : wsel_q + 1'b1);

  always_comb begin
    case (cfg_i.mode)
      MODE_RR:       sel = rr_sel;
      MODE_LEAST:    sel = ti[1];
      MODE_WEIGHTED: sel = wsel_q;
      default:       sel = BW'(div_rem);
    endcase
  end

  assign is_sel   = (cmd_q.req_type == REQ_SELECT);
  assign no_be    = is_sel && (cfg_i.count == '0);
  assign oor      = !is_sel && ({1'b0, cmd_q.target} >= cfg_i.count);
  assign idx      = is_sel ? sel : BW'(cmd_q.target);
  assign conn_cur = conn_q[idx];
  assign req_cur  = req_q[idx];

  always_comb begin
    conn_new = conn_cur;
    if (cmd_q.req_type == REQ_OPEN) begin
      if (conn_cur != '1) begin
        conn_new = conn_cur + 1'b1;
      end
    end else if (conn_cur != '0) begin
      conn_new = conn_cur - 1'b1;
    end
  end

  always_comb begin
    res_d = '0;
    if (no_be) begin
      res_d.status = STAT_NO_BACKEND;
    end else if (is_sel) begin
      res_d.chosen    = CHOSEN_W'(sel);
      res_d.total     = req_cur + 1'b1;
      res_d.open_conn = OPEN_W'(conn_cur);
      res_d.status    = STAT_SELECTED;
    end else if (oor) begin
      res_d.chosen = cmd_q.target;
      res_d.status = STAT_OUT_RANGE;
    end else begin
      res_d.chosen    = cmd_q.target;
      res_d.total     = req_cur;
      res_d.open_conn = OPEN_W'(conn_new);
      res_d.status    = STAT_UPDATED;
    end
  end

  assign exec_fire = (state_q == S_EXEC) && (!out_valid_q || res_ready_i);
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign div_start = cmd_pop_o && (cmd_i.req_type == REQ_SELECT) &&
                     (cfg_i.mode == MODE_HASH) && (cfg_i.count != '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_pop_o) begin
          state_d = div_start ? S_DIV : S_EXEC;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  bsel_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cmd_i.hash),
    .divisor_i  (cfg_i.count),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (exec_fire) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rr_q        <= '0;
      wsel_q      <= '0;
      wpos_q      <= '0;
      for (int i = 0; i < MAX_BACKENDS; i++) begin
        conn_q[i] <= '0;
        req_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (exec_fire && is_sel && !no_be) begin
        req_q[idx] <= req_cur + 1'b1;
      end
      if (exec_fire && !is_sel && !oor) begin
        conn_q[idx] <= conn_new;
      end
      if (cfg_clr_i) begin
        rr_q   <= '0;
        wsel_q <= '0;
        wpos_q <= '0;
      end else if (exec_fire && is_sel && !no_be) begin
        if (cfg_i.mode == MODE_RR) begin
          rr_q <= rr_next;
        end
        if (cfg_i.mode == MODE_WEIGHTED) begin
          wsel_q <= wsel_next;
          wpos_q <= wpos_next;
        end
      end
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_pop_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q != S_IDLE))
    else $error("command popped but back part stayed idle");

  a_wpos_in_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpos_q < w_cur)
    else $error("weighted position beyond current backend weight");

  a_div_only_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> ((cfg_i.mode == MODE_HASH) && (cfg_i.count != '0)))
    else $error("remainder wait outside key hash mode");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/backend_selector_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// backend_selector_unit - load-balancer backend selection
// Picks one of up to MAX_BACKENDS backends per select word and tracks
// per-backend open connections and request totals.
// ----------------------------------------------------------------------------
// Usage: each input word is a select request, a client key byte, a connection
// open or a connection close (tuser). Key bytes fold into a running hash and
// produce no output word; every other word produces exactly one. The front
// takes a word each cycle while its two-entry command queue has room; the back
// pops a command, then executes it into the output register once that is free
// or being read; in key hash mode a select waits between the two for 16
// remainder steps and the done flag, where a remainder unit reduces the
// 32-bit hash by the backend count two bits per cycle. A combinational min
// tree over the open counts finds least connections, lowest index on ties.
// Weighted mode walks each backend for as many selects as its weight. Any
// write to a listed register clears the rotation and weight positions;
// write configuration only while no word is in flight.
module backend_selector_unit import bsel_pkg::*; #(
  parameter int MAX_BACKENDS = MAX_BACKENDS_DEF,
  parameter int CONN_BITS    = CONN_BITS_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [WEIGHTS_W-1:0]  cfg_wdata_i,
  // Input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // key_byte, target_backend
  input  wire logic [REQ_TYPE_W-1:0] s_axis_tuser,  // req_type
  // Result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]       m_axis_tdata,  // chosen_backend, request_total,
                                                    // open_connections
  output logic [STATUS_W-1:0]        m_axis_tuser   // status
);

  // Configuration registers
  logic [MODE_W-1:0]    mode_q;
  logic [COUNT_W-1:0]   active_q;
  logic [WEIGHTS_W-1:0] weights_q;
  logic                 cfg_hit;
  cfg_t                 cfg;

  // Front to queue, queue to back
  logic fifo_push, fifo_full, fifo_pop, fifo_empty;
  cmd_t front_cmd, head_cmd;
  res_t res;

  // Decode the register index; a write outside the list is dropped
  always_comb begin
    unique case (cfg_addr_i) inside
      REG_MODE, REG_ACTIVE, REG_WEIGHTS: cfg_hit = cfg_we_i;
      default:                           cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_RR;
      active_q  <= '0;
      weights_q <= WEIGHTS_RESET;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_MODE) begin
        mode_q <= cfg_wdata_i[MODE_W-1:0];
      end
      if (cfg_addr_i == REG_ACTIVE) begin
        active_q <= cfg_wdata_i[COUNT_W-1:0];
      end
      if (cfg_addr_i == REG_WEIGHTS) begin
        weights_q <= cfg_wdata_i;
      end
    end
  end

  // Clamp the backend count to the storage size
  always_comb begin
    cfg.mode    = mode_q;
    cfg.weights = weights_q;
    if ((MAX_BACKENDS < (1 << COUNT_W)) && (active_q > COUNT_W'(MAX_BACKENDS))) begin
      cfg.count = COUNT_W'(MAX_BACKENDS);
    end else begin
      cfg.count = active_q;
    end
  end

  // Front: classify words, fold key bytes into the hash
  bsel_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .req_type_i (s_axis_tuser),
    .key_byte_i (s_axis_tdata[BYTE_W-1:0]),
    .target_i   (s_axis_tdata[BYTE_W +: TARGET_W]),
    .full_i     (fifo_full),
    .push_o     (fifo_push),
    .cmd_o      (front_cmd)
  );

  // Queue: decouple the front from the back
  bsel_cmd_fifo #(
    .DEPTH (CMDQ_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (front_cmd),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .data_o  (head_cmd)
  );

  // Back: select, count, and hold the result word
  bsel_back #(
    .MAX_BACKENDS (MAX_BACKENDS),
    .CONN_BITS    (CONN_BITS),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cfg_clr_i   (cfg_hit),
    .cmd_valid_i (!fifo_empty),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (fifo_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack the result word, lowest field first, zero pad to whole bytes
  assign m_axis_tdata = M_TDATA_W'({res.open_conn, res.total, res.chosen});
  assign m_axis_tuser = res.status;

endmodule

`default_nettype wire
